// File: sv/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
`default_nettype none
package modexp_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_FINISH
  } state_t;

  // Control for one step of the shared modular adder pair
  typedef struct packed {
    logic add_en;    // fold x into the partial product
    logic carry_in;  // extra one into the doubling path
  } step_ctl_t;

endpackage
`default_nettype wire

// File: sv/modexp_step_unit.sv
// Shift-and-add step: conditional modular add and modular doubling.
`default_nettype none
module modexp_step_unit
  import modexp_pkg::*;
(
  input  wire word_t     modulus,
  input  wire word_t     part,
  input  wire word_t     x_val,
  input  wire step_ctl_t ctl,
  output word_t          part_nxt,
  output word_t          x_nxt
);

  logic [WORD_W:0] sum_add;
  logic [WORD_W:0] sum_dbl;
  logic [WORD_W:0] mod_ext;

  // Operands stay below the modulus, so one subtract brings each sum back in range
  always_comb begin
    mod_ext = {1'b0, modulus};
    sum_add = {1'b0, part} + {1'b0, x_val};
    sum_dbl = {1'b0, x_val} + {1'b0, x_val} + {{WORD_W{1'b0}}, ctl.carry_in};
    if (sum_add >= mod_ext) begin
      sum_add = sum_add - mod_ext;
    end
    if (sum_dbl >= mod_ext) begin
      sum_dbl = sum_dbl - mod_ext;
    end
    part_nxt = ctl.add_en ? sum_add[WORD_W-1:0] : part;
    x_nxt    = sum_dbl[WORD_W-1:0];
  end

endmodule
`default_nettype wire

// File: sv/modular_exponentiation.sv
// Modular exponentiation: base^exponent mod modulus, left-to-right square-and-multiply.
// Sequence: the base is first reduced mod the modulus, then each exponent bit takes a squaring
// pass and, for a set bit, a multiply pass; a finish state then loads the result register.
// Flow: one item at a time; a zero modulus goes straight to the finish state and flags the
// error; a result held by out_ready stalls the finish state and the input.
// Reset: synchronous active-low rst_n clears the modulus to 0 and all handshake state.
`default_nettype none
module modular_exponentiation
  import modexp_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire word_t cfg_modulus,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire word_t in_base_value,
  input  wire word_t in_exponent,
  output logic       out_valid,
  input  wire        out_ready,
  output word_t      out_result,
  output logic       out_error
);

  state_t           state_r, state_nxt;
  word_t            modulus_r;
  word_t            base_r, base_nxt;
  word_t            exp_r, exp_nxt;
  word_t            acc_r, acc_nxt;
  word_t            part_r, part_nxt;
  word_t            x_r, x_nxt;
  word_t            y_r, y_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] ecnt_r, ecnt_nxt;
  logic             err_r, err_nxt;
  logic             out_valid_r;
  word_t            out_result_r;
  logic             out_error_r;
  logic             out_load;

  step_ctl_t        ctl;
  word_t            step_part;
  word_t            step_x;
  word_t            one_mod;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_error  = out_error_r;

  assign one_mod = (modulus_r == word_t'(1)) ? '0 : word_t'(1);

  modexp_step_unit u_step (
    .modulus  (modulus_r),
    .part     (part_r),
    .x_val    (x_r),
    .ctl      (ctl),
    .part_nxt (step_part),
    .x_nxt    (step_x)
  );

  always_comb begin
    state_nxt    = state_r;
    base_nxt     = base_r;
    exp_nxt      = exp_r;
    acc_nxt      = acc_r;
    part_nxt     = part_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    cnt_nxt      = cnt_r;
    ecnt_nxt     = ecnt_r;
    err_nxt      = err_r;
    out_load     = 1'b0;
    ctl.add_en   = 1'b0;
    ctl.carry_in = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          base_nxt = in_base_value;
          exp_nxt  = in_exponent;
          x_nxt    = '0;
          cnt_nxt  = '0;
          ecnt_nxt = '0;
          acc_nxt  = '0;
          if (modulus_r == '0) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FINISH;
          end else begin
            err_nxt   = 1'b0;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        // r = (2r + next base bit) mod n, base bits MSB first
        ctl.carry_in = base_r[WORD_W-1];
        x_nxt        = step_x;
        base_nxt     = {base_r[WORD_W-2:0], 1'b0};
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          base_nxt  = step_x;
          acc_nxt   = one_mod;
          part_nxt  = '0;
          x_nxt     = one_mod;
          y_nxt     = one_mod;
          cnt_nxt   = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE, ST_MULT: begin
        ctl.add_en = y_r[0];
        part_nxt   = step_part;
        x_nxt      = step_x;
        y_nxt      = {1'b0, y_r[WORD_W-1:1]};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          acc_nxt  = step_part;
          part_nxt = '0;
          x_nxt    = step_part;
          cnt_nxt  = '0;
          if (state_r == ST_SQUARE && exp_r[WORD_W-1]) begin
            y_nxt     = base_r;
            state_nxt = ST_MULT;
          end else begin
            // advance to the next exponent bit
            y_nxt    = step_part;
            exp_nxt  = {exp_r[WORD_W-2:0], 1'b0};
            ecnt_nxt = ecnt_r + 1'b1;
            if (ecnt_r == CNT_LAST) begin
              state_nxt = ST_FINISH;
            end else begin
              state_nxt = ST_SQUARE;
            end
          end
        end
      end
      ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      modulus_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        modulus_r <= cfg_modulus;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    acc_r  <= acc_nxt;
    part_r <= part_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    cnt_r  <= cnt_nxt;
    ecnt_r <= ecnt_nxt;
    err_r  <= err_nxt;
    if (out_load) begin
      out_result_r <= err_r ? '0 : acc_r;
      out_error_r  <= err_r;
    end
  end

endmodule
`default_nettype wire
